[rtl/smab_pkg.sv]
// smab_pkg: widths, constants, register codes and the dimension clamp
// for the scaled matte alpha blend block; no dependencies
`default_nettype none

package smab_pkg;

  // field widths
  localparam int MADDR_W  = 12;
  localparam int CHAN_W   = 8;
  localparam int CNT_W    = 13;
  localparam int OFF_W    = 13;
  localparam int DIM_W    = 14;
  localparam int STRIDE_W = 13;
  localparam int CFG_W    = 14;
  localparam int CFG_IDX_W = 3;

  // scaled position: count * span stays below 2**26, and so does offset + quotient
  localparam int QUO_W = 26;
  localparam int POS_W = 26;
  // byte address of the matte read: pos * stride + pos
  localparam int ADR_W = POS_W + STRIDE_W + 1;

  localparam logic [DIM_W-1:0] MAX_DIM = 14'd8192;

  // blend arithmetic
  localparam logic [CHAN_W-1:0] FULL_ALPHA = 8'd255;
  localparam logic [15:0]       ROUND_ADD  = 16'd127;
  // x / 255 == (x * 32897) >> 23 for every x below 66052
  localparam logic [16:0]       RECIP_255  = 17'd32897;
  localparam int                RECIP_SHIFT = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATTE_DEPTH = 3'd0,
    REG_COL_OFFSET  = 3'd1,
    REG_ROW_OFFSET  = 3'd2,
    REG_SPAN_WIDTH  = 3'd3,
    REG_SPAN_HEIGHT = 3'd4,
    REG_OUT_WIDTH   = 3'd5,
    REG_OUT_HEIGHT  = 3'd6,
    REG_STRIDE      = 3'd7
  } cfg_reg_t;

  localparam logic OP_MATTE_WRITE = 1'b0;
  localparam logic OP_BLEND       = 1'b1;

  // dimensions are used in the range 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MAX_DIM) begin
      r = MAX_DIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/smab_if.sv]
// smab_in_if and smab_out_if: valid/ready channels for pixel and matte words
// in and blended words out; depends on smab_pkg
`default_nettype none

interface smab_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [smab_pkg::MADDR_W-1:0] matte_address;
  logic [smab_pkg::CHAN_W-1:0] matte_data;
  logic [smab_pkg::CHAN_W-1:0] src_blue;
  logic [smab_pkg::CHAN_W-1:0] src_green;
  logic [smab_pkg::CHAN_W-1:0] src_red;
  logic [smab_pkg::CHAN_W-1:0] dst_blue;
  logic [smab_pkg::CHAN_W-1:0] dst_green;
  logic [smab_pkg::CHAN_W-1:0] dst_red;

  modport source (
    output valid, operation, matte_address, matte_data,
    output src_blue, src_green, src_red, dst_blue, dst_green, dst_red,
    input  ready
  );
  modport sink (
    input  valid, operation, matte_address, matte_data,
    input  src_blue, src_green, src_red, dst_blue, dst_green, dst_red,
    output ready
  );
endinterface

interface smab_out_if;
  logic                        valid;
  logic                        ready;
  logic [smab_pkg::CHAN_W-1:0] out_blue;
  logic [smab_pkg::CHAN_W-1:0] out_green;
  logic [smab_pkg::CHAN_W-1:0] out_red;
  logic                        frame_last;
  logic                        matte_fault;

  modport source (
    output valid, out_blue, out_green, out_red, frame_last, matte_fault,
    input  ready
  );
  modport sink (
    input  valid, out_blue, out_green, out_red, frame_last, matte_fault,
    output ready
  );
endinterface

`default_nettype wire

[rtl/smab_div.sv]
// smab_div: (count * span) / divisor by restoring division, one quotient bit
// per cycle; depends on smab_pkg
`default_nettype none

module smab_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [smab_pkg::CNT_W-1:0]    count,
  input  wire logic [smab_pkg::DIM_W-1:0]    span,
  input  wire logic [smab_pkg::DIM_W-1:0]    divisor,
  output logic                               done,
  output logic      [smab_pkg::QUO_W-1:0]    quot
);

  localparam int QW     = smab_pkg::QUO_W;
  localparam int DW     = smab_pkg::DIM_W;
  localparam int STEP_W = $clog2(QW + 1);

  logic [smab_pkg::CNT_W+DW-1:0] prod;
  logic [QW-1:0]     nq_r, nq_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     div_r;
  logic [STEP_W-1:0] step_r;
  logic [DW:0]       trial;
  logic              ge;

  assign prod = count * span;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial   = {rem_r, nq_r[QW-1]};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? DW'(trial - {1'b0, div_r}) : trial[DW-1:0];
    nq_nxt  = {nq_r[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= STEP_W'(QW);
    end else if (step_r != '0) begin
      step_r <= step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= prod[QW-1:0];
      rem_r <= '0;
      div_r <= divisor;
    end else if (step_r != '0) begin
      nq_r  <= nq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = (step_r == '0);
  assign quot = nq_r;

endmodule

`default_nettype wire

[rtl/smab_mix_lane.sv]
// smab_mix_lane: one color channel of the blend, (s*a + d*(255-a) + 127) / 255
// in two register stages; depends on smab_pkg
`default_nettype none

module smab_mix_lane (
  input  wire logic                          clk,
  input  wire logic [smab_pkg::CHAN_W-1:0]   src,
  input  wire logic [smab_pkg::CHAN_W-1:0]   dst,
  input  wire logic [smab_pkg::CHAN_W-1:0]   alpha,
  output logic      [smab_pkg::CHAN_W-1:0]   res
);

  localparam int CW = smab_pkg::CHAN_W;

  logic [15:0]   src_term, dst_term, sum_nxt;
  logic [15:0]   sum_r;
  logic [32:0]   scaled;
  logic [CW-1:0] res_r;

  always_comb begin
    src_term = src * alpha;
    dst_term = dst * (smab_pkg::FULL_ALPHA - alpha);
    sum_nxt  = src_term + dst_term + smab_pkg::ROUND_ADD;
  end

  // divide by 255 through the reciprocal
  assign scaled = sum_r * smab_pkg::RECIP_255;

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    res_r <= scaled[smab_pkg::RECIP_SHIFT +: CW];
  end

  assign res = res_r;

endmodule

`default_nettype wire

[rtl/scaled_matte_alpha_blend_top.sv]
// scaled_matte_alpha_blend_top: matte store, raster counters, scaling
// dividers, three blend lanes and the output register; depends on smab_pkg,
// smab_if, smab_div and smab_mix_lane
`default_nettype none

// A matte write word (operation 0) is stored as it is accepted, if its address
// lies inside the store. A blend word (operation 1) holds off the next word
// until its result is loaded into the output register: two bit-serial dividers
// run side by side to scale the column and row into the matte window (26 steps),
// then the address multiply, the registered matte read and the two stages of the
// three channel lanes follow. The result sits in an output register, so a new
// word is taken while it waits. Configuration is written on cfg_we with cfg_index
// selecting the register; a write takes effect on the next cycle.

module scaled_matte_alpha_blend_top #(
  parameter int MATTE_BYTES = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  smab_in_if.sink                                 in_ch,
  smab_out_if.source                              out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [smab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [smab_pkg::CFG_W-1:0]         cfg_data
);

  localparam int AW  = $clog2(MATTE_BYTES);
  localparam int WCW = (AW + 1 > smab_pkg::MADDR_W + 1) ? AW + 1 : smab_pkg::MADDR_W + 1;
  localparam int CHW = smab_pkg::CHAN_W;
  localparam int CNW = smab_pkg::CNT_W;
  localparam int DMW = smab_pkg::DIM_W;
  localparam int PSW = smab_pkg::POS_W;
  localparam int ADW = smab_pkg::ADR_W;
  localparam int STW = smab_pkg::STRIDE_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_MIX0 = 7'b0010000,
    S_MIX1 = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic                        depth_r;
  logic [smab_pkg::OFF_W-1:0]  col_offset_r, row_offset_r;
  logic [DMW-1:0]              span_width_r, span_height_r, out_width_r, out_height_r;
  logic [STW-1:0]              stride_r;

  // raster position
  logic [CNW-1:0] col_cnt_r, row_cnt_r;
  logic [DMW-1:0] ow_c, oh_c, sw_c, sh_c;
  logic           col_end, row_end;

  // per-word registers
  logic [CHW-1:0] src_b_r, src_g_r, src_r_r, dst_b_r, dst_g_r, dst_r_r;
  logic           frame_last_r;
  logic [PSW-1:0] mx_r, my_r, mx_sel;
  logic [PSW+STW-1:0] row_base;
  logic [ADW-1:0] addr_r;
  logic [2:0]     bit_sel_r;
  logic [CHW-1:0] rd_data_r;
  logic           fault_r;
  logic [CHW-1:0] alpha;

  // matte store
  logic [CHW-1:0] matte_mem [MATTE_BYTES];
  logic [WCW-1:0] waddr_ext;
  logic           mem_we;
  logic           rd_in_range;

  // dividers
  logic                      div_start;
  logic                      dx_done, dy_done;
  logic [smab_pkg::QUO_W-1:0] quot_x, quot_y;

  // lanes
  logic [CHW-1:0] mix_b, mix_g, mix_r;

  // output register
  logic           out_valid_r;
  logic [CHW-1:0] out_b_r, out_g_r, out_rd_r;
  logic           out_last_r, out_fault_r;
  logic           out_load;

  logic in_acc, pix_acc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign pix_acc     = in_acc & (in_ch.operation == smab_pkg::OP_BLEND);
  assign div_start   = pix_acc;

  // ---------------- configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r       <= 1'b1;
      col_offset_r  <= '0;
      row_offset_r  <= '0;
      span_width_r  <= DMW'(1);
      span_height_r <= DMW'(1);
      out_width_r   <= DMW'(1);
      out_height_r  <= DMW'(1);
      stride_r      <= STW'(1);
    end else if (cfg_we) begin
      unique case (smab_pkg::cfg_reg_t'(cfg_index))
        smab_pkg::REG_MATTE_DEPTH: depth_r       <= cfg_data[0];
        smab_pkg::REG_COL_OFFSET:  col_offset_r  <= cfg_data[smab_pkg::OFF_W-1:0];
        smab_pkg::REG_ROW_OFFSET:  row_offset_r  <= cfg_data[smab_pkg::OFF_W-1:0];
        smab_pkg::REG_SPAN_WIDTH:  span_width_r  <= cfg_data[DMW-1:0];
        smab_pkg::REG_SPAN_HEIGHT: span_height_r <= cfg_data[DMW-1:0];
        smab_pkg::REG_OUT_WIDTH:   out_width_r   <= cfg_data[DMW-1:0];
        smab_pkg::REG_OUT_HEIGHT:  out_height_r  <= cfg_data[DMW-1:0];
        smab_pkg::REG_STRIDE:      stride_r      <= cfg_data[STW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- raster counters
  always_comb begin
    ow_c    = smab_pkg::clamp_dim(out_width_r);
    oh_c    = smab_pkg::clamp_dim(out_height_r);
    sw_c    = smab_pkg::clamp_dim(span_width_r);
    sh_c    = smab_pkg::clamp_dim(span_height_r);
    col_end = (DMW'(col_cnt_r) + DMW'(1)) >= ow_c;
    row_end = (DMW'(row_cnt_r) + DMW'(1)) >= oh_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (pix_acc) begin
      if (col_end) begin
        col_cnt_r <= '0;
        row_cnt_r <= row_end ? '0 : row_cnt_r + CNW'(1);
      end else begin
        col_cnt_r <= col_cnt_r + CNW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      src_b_r      <= in_ch.src_blue;
      src_g_r      <= in_ch.src_green;
      src_r_r      <= in_ch.src_red;
      dst_b_r      <= in_ch.dst_blue;
      dst_g_r      <= in_ch.dst_green;
      dst_r_r      <= in_ch.dst_red;
      frame_last_r <= col_end & row_end;
    end
  end

  // ---------------- scaling dividers, column and row side by side
  smab_div u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .count   (col_cnt_r),
    .span    (sw_c),
    .divisor (ow_c),
    .done    (dx_done),
    .quot    (quot_x)
  );

  smab_div u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .count   (row_cnt_r),
    .span    (sh_c),
    .divisor (oh_c),
    .done    (dy_done),
    .quot    (quot_y)
  );

  // ---------------- matte address
  assign mx_sel   = depth_r ? mx_r : (mx_r >> 3);
  assign row_base = my_r * stride_r;

  always_ff @(posedge clk) begin
    if (state_r == S_DIV && dx_done && dy_done) begin
      mx_r <= PSW'(col_offset_r) + quot_x;
      my_r <= PSW'(row_offset_r) + quot_y;
    end
    if (state_r == S_MUL) begin
      addr_r    <= ADW'(row_base) + ADW'(mx_sel);
      bit_sel_r <= mx_r[2:0];
    end
  end

  // ---------------- matte store
  assign waddr_ext   = WCW'(in_ch.matte_address);
  assign mem_we      = in_acc && (in_ch.operation == smab_pkg::OP_MATTE_WRITE)
                       && (waddr_ext < WCW'(MATTE_BYTES));
  assign rd_in_range = addr_r < ADW'(MATTE_BYTES);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      matte_mem[waddr_ext[AW-1:0]] <= in_ch.matte_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      rd_data_r <= matte_mem[addr_r[AW-1:0]];
      fault_r   <= ~rd_in_range;
    end
  end

  // one-bit samples are taken msb first
  always_comb begin
    if (fault_r) begin
      alpha = '0;
    end else if (depth_r) begin
      alpha = rd_data_r;
    end else begin
      alpha = rd_data_r[3'd7 - bit_sel_r] ? smab_pkg::FULL_ALPHA : '0;
    end
  end

  // ---------------- blend lanes
  smab_mix_lane u_lane_b (
    .clk   (clk),
    .src   (src_b_r),
    .dst   (dst_b_r),
    .alpha (alpha),
    .res   (mix_b)
  );

  smab_mix_lane u_lane_g (
    .clk   (clk),
    .src   (src_g_r),
    .dst   (dst_g_r),
    .alpha (alpha),
    .res   (mix_g)
  );

  smab_mix_lane u_lane_r (
    .clk   (clk),
    .src   (src_r_r),
    .dst   (dst_r_r),
    .alpha (alpha),
    .res   (mix_r)
  );

  // ---------------- sequencer
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (pix_acc) state_nxt = S_DIV;
      S_DIV:  if (dx_done && dy_done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_RD;
      S_RD:   state_nxt = S_MIX0;
      S_MIX0: state_nxt = S_MIX1;
      S_MIX1: state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- merge lanes and flags into the output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_b_r     <= mix_b;
      out_g_r     <= mix_g;
      out_rd_r    <= mix_r;
      out_last_r  <= frame_last_r;
      out_fault_r <= fault_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_blue    = out_b_r;
  assign out_ch.out_green   = out_g_r;
  assign out_ch.out_red     = out_rd_r;
  assign out_ch.frame_last  = out_last_r;
  assign out_ch.matte_fault = out_fault_r;

endmodule

`default_nettype wire
